>>> hdl/mhts_pkg.sv
// ----------------------------------------------------------------------------
// mhts_pkg
// Shared types, sizes and helpers for the min-heap timer scheduler.
// ----------------------------------------------------------------------------
package mhts_pkg;

  localparam int CAPACITY = 32;
  localparam int ID_COUNT = 1024;
  localparam int TIME_BITS = 32;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = $clog2(ID_COUNT);
  localparam int WAIT_W = 20;
  localparam int CMD_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_ADJUST = 3'd1,
    CMD_FIRE   = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // One heap entry: timer id and absolute expiry time.
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] exp;
  } node_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_SLOT,
    OP_RD_HEAP_SLOT,
    OP_SET_MV,
    OP_NEW,
    OP_ST_FULL,
    OP_ST_UNKNOWN,
    OP_FIRE_SEL,
    OP_EMIT_FIRE,
    OP_REM_RD,
    OP_REM_LAST,
    OP_MV_FROM_RD,
    OP_DN_RD_C1,
    OP_CAND_LOAD,
    OP_CAND_LOAD_RD2,
    OP_CAND_PICK,
    OP_DN_MOVE,
    OP_PLACE,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_CLEAR,
    OP_RD_ROOT,
    OP_EXP_FIRE,
    OP_FIN_PREP,
    OP_EMIT_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic known;
    logic full;
    logic rem_mid;
    logic has_child;
    logic has_child2;
    logic mv_first;
    logic moved;
    logic at_root;
    logic parent_first;
    logic nonempty;
    logic due;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT_WAIT,
    S_KNOWN,
    S_FIRE_EMIT,
    S_REMOVE,
    S_REM_WAIT,
    S_DOWN_START,
    S_DN_C1,
    S_DN_C2,
    S_DN_CMP,
    S_DOWN_END,
    S_UP_START,
    S_UP_CMP,
    S_CONT,
    S_EXP_CHECK,
    S_EXP_CMP,
    S_FIN_RD,
    S_FIN_EMIT
  } state_t;

  // True when expiry a comes strictly before expiry b, seen from time now.
  function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b,
                                   input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] ka;
    logic [TIME_BITS-1:0] kb;
    ka = a - now;
    kb = b - now;
    return ka < kb;
  endfunction

endpackage

>>> hdl/mhts_req_if.sv
// ----------------------------------------------------------------------------
// mhts_req_if
// Command channel of the timer scheduler.
// ----------------------------------------------------------------------------
interface mhts_req_if;
  logic                          valid;
  logic                          ready;
  logic [mhts_pkg::CMD_W-1:0]    cmd;
  logic [mhts_pkg::ID_W-1:0]     timer_id;
  logic [mhts_pkg::WAIT_W-1:0]   timeout_ms;

  modport source (output valid, cmd, timer_id, timeout_ms, input ready);
  modport sink (input valid, cmd, timer_id, timeout_ms, output ready);
endinterface

>>> hdl/mhts_rsp_if.sv
// ----------------------------------------------------------------------------
// mhts_rsp_if
// Result channel of the timer scheduler.
// ----------------------------------------------------------------------------
interface mhts_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [mhts_pkg::ID_W-1:0]      fired_id;
  logic [mhts_pkg::STATUS_W-1:0]  status;
  logic                           has_timer;
  logic [mhts_pkg::WAIT_W-1:0]    next_wait_ms;
  logic [mhts_pkg::CNT_W-1:0]     timer_count;
  logic                           last;

  modport source (output valid, kind, fired_id, status, has_timer, next_wait_ms,
                  timer_count, last, input ready);
  modport sink (input valid, kind, fired_id, status, has_timer, next_wait_ms,
                timer_count, last, output ready);
endinterface

>>> hdl/min_heap_timer_scheduler.sv
// ----------------------------------------------------------------------------
// min_heap_timer_scheduler
// Timer queue kept as a binary min-heap on expiry time with an id-to-slot map.
//
//   Channel | Dir | Payload
//   req     | in  | cmd, timer_id, timeout_ms
//   rsp     | out | kind, fired_id, status, has_timer, next_wait_ms,
//           |     | timer_count, last
//
// One command at a time. Add, adjust and fire may also run a sift of the heap.
// A sift-down or a sift-up moves over up to 5 levels at 32 entries. Each
// expiry also runs the sift-down of its removal. The heap memory has a single
// read port. Reset empties the queue and zeroes the clock; no clearing pass is
// needed. A stalled rsp holds the sequencer.
// ----------------------------------------------------------------------------
module min_heap_timer_scheduler (
  input logic        clk,
  input logic        rst,
  mhts_req_if.sink   req,
  mhts_rsp_if.source rsp
);

  mhts_pkg::dp_cmd_t  cmd;
  mhts_pkg::dp_stat_t stat;
  logic               in_ready;

  assign req.ready = in_ready;

  // Sequencer.
  mhts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Heap datapath.
  mhts_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

>>> hdl/mhts_ctrl.sv
// ----------------------------------------------------------------------------
// mhts_ctrl
// Sequencer that steps the heap datapath through lookups, sifts and expiries.
// ----------------------------------------------------------------------------
module mhts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mhts_pkg::dp_stat_t stat,
  output mhts_pkg::dp_cmd_t  cmd
);

  mhts_pkg::state_t state;
  mhts_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op = mhts_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      mhts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mhts_pkg::OP_LOAD;
          state_next = mhts_pkg::S_DECODE;
        end
      end
      mhts_pkg::S_DECODE: begin
        case (stat.cmd)
          mhts_pkg::CMD_ADD, mhts_pkg::CMD_ADJUST, mhts_pkg::CMD_FIRE: begin
            cmd.op = mhts_pkg::OP_RD_SLOT;
            state_next = mhts_pkg::S_SLOT_WAIT;
          end
          mhts_pkg::CMD_TICK, mhts_pkg::CMD_QUERY: begin
            state_next = mhts_pkg::S_EXP_CHECK;
          end
          mhts_pkg::CMD_CLEAR: begin
            cmd.op = mhts_pkg::OP_CLEAR;
            state_next = mhts_pkg::S_FIN_RD;
          end
          default: begin
            state_next = mhts_pkg::S_FIN_RD;
          end
        endcase
      end
      mhts_pkg::S_SLOT_WAIT: begin
        cmd.op = mhts_pkg::OP_RD_HEAP_SLOT;
        state_next = mhts_pkg::S_KNOWN;
      end
      mhts_pkg::S_KNOWN: begin
        case (stat.cmd)
          mhts_pkg::CMD_ADD: begin
            if (stat.known) begin
              cmd.op = mhts_pkg::OP_SET_MV;
              state_next = mhts_pkg::S_DOWN_START;
            end else if (stat.full) begin
              cmd.op = mhts_pkg::OP_ST_FULL;
              state_next = mhts_pkg::S_FIN_RD;
            end else begin
              cmd.op = mhts_pkg::OP_NEW;
              state_next = mhts_pkg::S_UP_START;
            end
          end
          mhts_pkg::CMD_ADJUST: begin
            if (stat.known) begin
              cmd.op = mhts_pkg::OP_SET_MV;
              state_next = mhts_pkg::S_DOWN_START;
            end else begin
              cmd.op = mhts_pkg::OP_ST_UNKNOWN;
              state_next = mhts_pkg::S_FIN_RD;
            end
          end
          mhts_pkg::CMD_FIRE: begin
            if (stat.known) begin
              cmd.op = mhts_pkg::OP_FIRE_SEL;
              state_next = mhts_pkg::S_FIRE_EMIT;
            end else begin
              cmd.op = mhts_pkg::OP_ST_UNKNOWN;
              state_next = mhts_pkg::S_FIN_RD;
            end
          end
          default: begin
            state_next = mhts_pkg::S_FIN_RD;
          end
        endcase
      end
      mhts_pkg::S_FIRE_EMIT: begin
        if (stat.out_free) begin
          cmd.op = mhts_pkg::OP_EMIT_FIRE;
          state_next = mhts_pkg::S_REMOVE;
        end
      end
      mhts_pkg::S_REMOVE: begin
        if (stat.rem_mid) begin
          cmd.op = mhts_pkg::OP_REM_RD;
          state_next = mhts_pkg::S_REM_WAIT;
        end else begin
          cmd.op = mhts_pkg::OP_REM_LAST;
          state_next = mhts_pkg::S_CONT;
        end
      end
      mhts_pkg::S_REM_WAIT: begin
        cmd.op = mhts_pkg::OP_MV_FROM_RD;
        state_next = mhts_pkg::S_DOWN_START;
      end
      mhts_pkg::S_DOWN_START: begin
        if (stat.has_child) begin
          cmd.op = mhts_pkg::OP_DN_RD_C1;
          state_next = mhts_pkg::S_DN_C1;
        end else begin
          state_next = mhts_pkg::S_DOWN_END;
        end
      end
      mhts_pkg::S_DN_C1: begin
        if (stat.has_child2) begin
          cmd.op = mhts_pkg::OP_CAND_LOAD_RD2;
          state_next = mhts_pkg::S_DN_C2;
        end else begin
          cmd.op = mhts_pkg::OP_CAND_LOAD;
          state_next = mhts_pkg::S_DN_CMP;
        end
      end
      mhts_pkg::S_DN_C2: begin
        cmd.op = mhts_pkg::OP_CAND_PICK;
        state_next = mhts_pkg::S_DN_CMP;
      end
      mhts_pkg::S_DN_CMP: begin
        if (stat.mv_first) begin
          state_next = mhts_pkg::S_DOWN_END;
        end else begin
          cmd.op = mhts_pkg::OP_DN_MOVE;
          state_next = mhts_pkg::S_DOWN_START;
        end
      end
      mhts_pkg::S_DOWN_END: begin
        if (stat.moved) begin
          cmd.op = mhts_pkg::OP_PLACE;
          state_next = mhts_pkg::S_CONT;
        end else begin
          state_next = mhts_pkg::S_UP_START;
        end
      end
      mhts_pkg::S_UP_START: begin
        if (stat.at_root) begin
          cmd.op = mhts_pkg::OP_PLACE;
          state_next = mhts_pkg::S_CONT;
        end else begin
          cmd.op = mhts_pkg::OP_UP_RD;
          state_next = mhts_pkg::S_UP_CMP;
        end
      end
      mhts_pkg::S_UP_CMP: begin
        if (stat.parent_first) begin
          cmd.op = mhts_pkg::OP_PLACE;
          state_next = mhts_pkg::S_CONT;
        end else begin
          cmd.op = mhts_pkg::OP_UP_MOVE;
          state_next = mhts_pkg::S_UP_START;
        end
      end
      mhts_pkg::S_CONT: begin
        if (stat.cmd == mhts_pkg::CMD_TICK || stat.cmd == mhts_pkg::CMD_QUERY) begin
          state_next = mhts_pkg::S_EXP_CHECK;
        end else begin
          state_next = mhts_pkg::S_FIN_RD;
        end
      end
      mhts_pkg::S_EXP_CHECK: begin
        if (stat.nonempty) begin
          cmd.op = mhts_pkg::OP_RD_ROOT;
          state_next = mhts_pkg::S_EXP_CMP;
        end else begin
          state_next = mhts_pkg::S_FIN_RD;
        end
      end
      mhts_pkg::S_EXP_CMP: begin
        if (stat.due) begin
          cmd.op = mhts_pkg::OP_EXP_FIRE;
          state_next = mhts_pkg::S_FIRE_EMIT;
        end else begin
          state_next = mhts_pkg::S_FIN_RD;
        end
      end
      mhts_pkg::S_FIN_RD: begin
        cmd.op = mhts_pkg::OP_FIN_PREP;
        state_next = mhts_pkg::S_FIN_EMIT;
      end
      mhts_pkg::S_FIN_EMIT: begin
        if (stat.out_free) begin
          cmd.op = mhts_pkg::OP_EMIT_DONE;
          state_next = mhts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mhts_pkg::S_IDLE;
      end
    endcase
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mhts_pkg::OP_EMIT_DONE || cmd.op == mhts_pkg::OP_EMIT_FIRE)
      |-> stat.out_free)
    else $error("result loaded while output register busy");

  // A completion returns the sequencer to idle, where the next command is taken.
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == mhts_pkg::OP_EMIT_DONE |=> state == mhts_pkg::S_IDLE)
    else $error("completion not followed by idle");

  // A sift never walks on an empty heap.
  a_sift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == mhts_pkg::S_DOWN_START || state == mhts_pkg::S_UP_START)
      |-> stat.nonempty)
    else $error("sift on empty heap");

endmodule

>>> hdl/mhts_dp.sv
// ----------------------------------------------------------------------------
// mhts_dp
// Heap and slot memories, sift registers, clock and output register.
// ----------------------------------------------------------------------------
module mhts_dp (
  input  logic               clk,
  input  logic               rst,
  mhts_req_if.sink           req,
  mhts_rsp_if.source         rsp,
  input  mhts_pkg::dp_cmd_t  cmd,
  output mhts_pkg::dp_stat_t stat
);

  localparam int IDX_W = mhts_pkg::IDX_W;
  localparam int CNT_W = mhts_pkg::CNT_W;
  localparam int ID_W = mhts_pkg::ID_W;
  localparam int TB = mhts_pkg::TIME_BITS;
  localparam int WAIT_W = mhts_pkg::WAIT_W;

  // Memories.
  mhts_pkg::node_t hp_mem [mhts_pkg::CAPACITY];
  logic [CNT_W-1:0] sl_mem [mhts_pkg::ID_COUNT];

  mhts_pkg::node_t hp_rd;
  logic [CNT_W-1:0] sl_rd;
  logic hp_re;
  logic [IDX_W-1:0] hp_raddr;
  logic hp_we;
  logic [IDX_W-1:0] hp_waddr;
  mhts_pkg::node_t hp_wdata;

  // Registers.
  mhts_pkg::cmd_t cmd_q;
  logic [ID_W-1:0] id_q;
  logic [TB-1:0] exp_in;
  logic [TB-1:0] now;
  logic [CNT_W-1:0] size;
  logic [IDX_W-1:0] pos;
  mhts_pkg::node_t mv;
  mhts_pkg::node_t cand;
  logic [IDX_W-1:0] cand_idx;
  logic moved;
  logic slot_ok;
  logic [ID_W-1:0] fire_id;
  logic [mhts_pkg::STATUS_W-1:0] status_q;

  logic out_valid;
  logic out_kind;
  logic [ID_W-1:0] out_fired_id;
  logic [mhts_pkg::STATUS_W-1:0] out_status;
  logic out_has;
  logic [WAIT_W-1:0] out_wait;
  logic [CNT_W-1:0] out_count;
  logic out_last;

  // Index arithmetic around the current position.
  logic [CNT_W-1:0] child1;
  logic [CNT_W:0] child2;
  logic [IDX_W-1:0] parent;
  logic [CNT_W-1:0] size_m1;
  logic [TB-1:0] root_key;
  logic out_free;

  assign child1 = {pos, 1'b1};
  assign child2 = {1'b0, pos, 1'b0} + (CNT_W + 1)'(2);
  assign parent = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign size_m1 = size - CNT_W'(1);
  assign root_key = hp_rd.exp - now;
  assign out_free = !out_valid || rsp.ready;

  // Status to the controller.
  always_comb begin
    stat.cmd = cmd_q;
    stat.known = slot_ok && (hp_rd.id == id_q);
    stat.full = (size == CNT_W'(mhts_pkg::CAPACITY));
    stat.rem_mid = ({1'b0, pos} < size_m1);
    stat.has_child = (child1 < size);
    stat.has_child2 = (child2 < {1'b0, size});
    stat.mv_first = mhts_pkg::earlier(mv.exp, cand.exp, now);
    stat.moved = moved;
    stat.at_root = (pos == '0);
    stat.parent_first = mhts_pkg::earlier(hp_rd.exp, mv.exp, now);
    stat.nonempty = (size != '0);
    stat.due = (root_key <= TB'(cmd_q == mhts_pkg::CMD_TICK));
    stat.out_free = out_free;
  end

  // Memory port selection.
  always_comb begin
    hp_re = 1'b0;
    hp_raddr = '0;
    hp_we = 1'b0;
    hp_waddr = pos;
    hp_wdata = mv;
    case (cmd.op)
      mhts_pkg::OP_RD_HEAP_SLOT: begin
        hp_re = 1'b1;
        hp_raddr = sl_rd[IDX_W-1:0];
      end
      mhts_pkg::OP_REM_RD: begin
        hp_re = 1'b1;
        hp_raddr = size_m1[IDX_W-1:0];
      end
      mhts_pkg::OP_DN_RD_C1: begin
        hp_re = 1'b1;
        hp_raddr = child1[IDX_W-1:0];
      end
      mhts_pkg::OP_CAND_LOAD_RD2: begin
        hp_re = 1'b1;
        hp_raddr = child2[IDX_W-1:0];
      end
      mhts_pkg::OP_UP_RD: begin
        hp_re = 1'b1;
        hp_raddr = parent;
      end
      mhts_pkg::OP_RD_ROOT, mhts_pkg::OP_FIN_PREP: begin
        hp_re = 1'b1;
      end
      mhts_pkg::OP_DN_MOVE: begin
        hp_we = 1'b1;
        hp_wdata = cand;
      end
      mhts_pkg::OP_UP_MOVE: begin
        hp_we = 1'b1;
        hp_wdata = hp_rd;
      end
      mhts_pkg::OP_PLACE: begin
        hp_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Heap memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (hp_we) begin
      hp_mem[hp_waddr] <= hp_wdata;
    end
    if (hp_re) begin
      hp_rd <= hp_mem[hp_raddr];
    end
  end

  // Slot table follows every heap write.
  always_ff @(posedge clk) begin
    if (hp_we) begin
      sl_mem[hp_wdata.id] <= {1'b0, hp_waddr};
    end
    if (cmd.op == mhts_pkg::OP_RD_SLOT) begin
      sl_rd <= sl_mem[id_q];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      now <= '0;
    end else begin
      case (cmd.op)
        mhts_pkg::OP_NEW: size <= size + CNT_W'(1);
        mhts_pkg::OP_REM_RD, mhts_pkg::OP_REM_LAST: size <= size_m1;
        mhts_pkg::OP_CLEAR: size <= '0;
        mhts_pkg::OP_FIN_PREP: begin
          if (cmd_q == mhts_pkg::CMD_TICK) begin
            now <= now + TB'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      mhts_pkg::OP_LOAD: begin
        cmd_q <= mhts_pkg::cmd_t'(req.cmd);
        id_q <= req.timer_id;
        exp_in <= now + TB'(req.timeout_ms);
        status_q <= mhts_pkg::ST_OK;
      end
      mhts_pkg::OP_RD_HEAP_SLOT: begin
        slot_ok <= (sl_rd < size);
        pos <= sl_rd[IDX_W-1:0];
      end
      mhts_pkg::OP_SET_MV: begin
        mv.id <= id_q;
        mv.exp <= exp_in;
        moved <= 1'b0;
      end
      mhts_pkg::OP_NEW: begin
        mv.id <= id_q;
        mv.exp <= exp_in;
        moved <= 1'b0;
        pos <= size[IDX_W-1:0];
      end
      mhts_pkg::OP_ST_FULL: status_q <= mhts_pkg::ST_FULL;
      mhts_pkg::OP_ST_UNKNOWN: status_q <= mhts_pkg::ST_UNKNOWN;
      mhts_pkg::OP_FIRE_SEL: fire_id <= id_q;
      mhts_pkg::OP_MV_FROM_RD: begin
        mv <= hp_rd;
        moved <= 1'b0;
      end
      mhts_pkg::OP_CAND_LOAD, mhts_pkg::OP_CAND_LOAD_RD2: begin
        cand <= hp_rd;
        cand_idx <= child1[IDX_W-1:0];
      end
      mhts_pkg::OP_CAND_PICK: begin
        if (mhts_pkg::earlier(hp_rd.exp, cand.exp, now)) begin
          cand <= hp_rd;
          cand_idx <= child2[IDX_W-1:0];
        end
      end
      mhts_pkg::OP_DN_MOVE: begin
        pos <= cand_idx;
        moved <= 1'b1;
      end
      mhts_pkg::OP_UP_MOVE: pos <= parent;
      mhts_pkg::OP_EXP_FIRE: begin
        fire_id <= hp_rd.id;
        pos <= '0;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == mhts_pkg::OP_EMIT_FIRE || cmd.op == mhts_pkg::OP_EMIT_DONE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mhts_pkg::OP_EMIT_FIRE) begin
      out_kind <= mhts_pkg::KIND_FIRED;
      out_fired_id <= fire_id;
      out_status <= mhts_pkg::ST_OK;
      out_has <= 1'b0;
      out_wait <= '0;
      out_count <= '0;
      out_last <= 1'b0;
    end else if (cmd.op == mhts_pkg::OP_EMIT_DONE) begin
      out_kind <= mhts_pkg::KIND_DONE;
      out_fired_id <= '0;
      out_status <= status_q;
      out_has <= (size != '0);
      out_wait <= (size != '0) ? root_key[WAIT_W-1:0] : '0;
      out_count <= size;
      out_last <= 1'b1;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.kind = out_kind;
  assign rsp.fired_id = out_fired_id;
  assign rsp.status = out_status;
  assign rsp.has_timer = out_has;
  assign rsp.next_wait_ms = out_wait;
  assign rsp.timer_count = out_count;
  assign rsp.last = out_last;

  // The heap never holds more than its capacity.
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    size <= CNT_W'(mhts_pkg::CAPACITY))
    else $error("heap size above capacity");

  // A node is only placed inside the live part of the heap.
  a_place_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op == mhts_pkg::OP_PLACE |-> {1'b0, pos} < size)
    else $error("node placed outside heap");

  // A completion leaves the output register marked last.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    cmd.op == mhts_pkg::OP_EMIT_DONE |=> out_valid && out_last)
    else $error("completion not presented as last");

endmodule
